// ===== design/uvc_payload_frame_assembler_core_defines.svh =====
// Assertion macros for the payload frame assembler RTL.
`ifndef UVC_PAYLOAD_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define UVC_PAYLOAD_FRAME_ASSEMBLER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define UPFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define UPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UPFA_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define UPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/upfa_pkg.sv =====
// Types and constants of the payload frame assembler.
package upfa_pkg;

   localparam int unsigned FRAME_BYTES_W  = 21;
   localparam int unsigned OFFSET_W       = 20;
   localparam int unsigned SUM_W          = 22;
   localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RESET = 21'd614400;

   // Header layout.
   localparam int unsigned HDR_LEN        = 12;
   localparam int unsigned HDR_LEN_POS    = 0;
   localparam int unsigned HDR_FLAGS_POS  = 1;
   localparam int unsigned HDR_PTS_POS    = 2;
   localparam int unsigned HDR_PTS_BYTES  = 4;

   // Header flag bit positions.
   localparam int unsigned FLAG_ERR_BIT   = 6;
   localparam int unsigned FLAG_PTS_BIT   = 2;
   localparam int unsigned FLAG_EOF_BIT   = 1;
   localparam int unsigned FLAG_FID_BIT   = 0;

   // Input word kinds.
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      PC_DISCARD = 2'd0,
      PC_FIRST   = 2'd1,
      PC_INTER   = 2'd2,
      PC_LAST    = 2'd3
   } pclass_type;

   typedef enum logic [2:0] {
      CLS_UNDECIDED = 3'd0,
      CLS_BAD       = 3'd1,
      CLS_NEW       = 3'd2,
      CLS_CONT      = 3'd3,
      CLS_EOF       = 3'd4
   } cls_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       transfer_end;
   } req_type;

   typedef struct packed {
      logic                write_enable;
      logic [OFFSET_W-1:0] write_offset;
      logic [7:0]          write_byte;
      logic                frame_done;
      logic                payload_discarded;
   } rsp_type;

endpackage

// ===== design/upfa_parser.sv =====
// Per-word header parser, frame tracker and store address generator.
module upfa_parser
   import upfa_pkg::*;
#(
   parameter int PAYLOAD_BYTES   = 2048,
   parameter int MAX_FRAME_BYTES = 1048576
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  req_type                  req,
   input  logic [FRAME_BYTES_W-1:0] frame_bytes,
   output rsp_type                  rsp
);

   localparam int POS_W = $clog2(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HDR_LEN - 1);
   localparam logic [POS_W-1:0] POS_DATA     = POS_W'(HDR_LEN);
   localparam logic [POS_W-1:0] POS_PAY_LAST = POS_W'(PAYLOAD_BYTES - 1);
   localparam logic [POS_W-1:0] POS_LEN      = POS_W'(HDR_LEN_POS);
   localparam logic [POS_W-1:0] POS_FLAGS    = POS_W'(HDR_FLAGS_POS);
   localparam logic [POS_W-1:0] POS_PTS0     = POS_W'(HDR_PTS_POS);
   localparam logic [POS_W-1:0] POS_PTS3     = POS_W'(HDR_PTS_POS + HDR_PTS_BYTES - 1);

   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [7:0]               flags_ff, flags_in;
   logic                     len_ok_ff, len_ok_in;
   logic [3:0][7:0]          pts_ff, pts_in;
   logic [31:0]              prev_pts_ff, prev_pts_in;
   logic                     prev_fid_ff, prev_fid_in;
   pclass_type               pclass_ff, pclass_in;
   cls_type                  cls_ff, cls_in;
   logic [FRAME_BYTES_W-1:0] fill_ff, fill_in;

   cls_type                  cls_hdr;
   cls_type                  cls_now;
   logic                     frame_open;
   logic                     payload_end;
   logic [POS_W-1:0]         data_n;
   logic [POS_W-1:0]         data_idx;
   logic [SUM_W-1:0]         fill_sum;
   logic [SUM_W-1:0]         wr_offs;
   logic                     wr_can;
   logic [1:0]               pts_idx;

   // Header verdict, valid on the last header byte.
   always_comb begin
      if (!len_ok_ff || flags_ff[FLAG_ERR_BIT] || !flags_ff[FLAG_PTS_BIT]) begin
         cls_hdr = CLS_BAD;
      end else if (pts_ff != prev_pts_ff || flags_ff[FLAG_FID_BIT] != prev_fid_ff) begin
         cls_hdr = CLS_NEW;
      end else if (flags_ff[FLAG_EOF_BIT]) begin
         cls_hdr = CLS_EOF;
      end else begin
         cls_hdr = CLS_CONT;
      end
   end

   assign cls_now     = (pos_ff == POS_HDR_LAST) ? cls_hdr : cls_ff;
   assign frame_open  = pclass_ff inside {PC_FIRST, PC_INTER};
   assign payload_end = req.transfer_end || (pos_ff == POS_PAY_LAST);
   assign data_n      = pos_ff - POS_HDR_LAST;
   assign data_idx    = pos_ff - POS_DATA;
   assign fill_sum    = SUM_W'(fill_ff) + SUM_W'(data_n);
   assign pts_idx     = 2'(pos_ff - POS_PTS0);

   always_comb begin
      wr_can  = 1'b0;
      wr_offs = SUM_W'(data_idx);
      if (pos_ff >= POS_DATA) begin
         if (cls_ff == CLS_NEW) begin
            wr_can = 1'b1;
         end else if ((cls_ff == CLS_CONT || cls_ff == CLS_EOF) && frame_open) begin
            wr_can  = 1'b1;
            wr_offs = SUM_W'(fill_ff) + SUM_W'(data_idx);
         end
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      flags_in    = flags_ff;
      len_ok_in   = len_ok_ff;
      pts_in      = pts_ff;
      prev_pts_in = prev_pts_ff;
      prev_fid_in = prev_fid_ff;
      pclass_in   = pclass_ff;
      cls_in      = cls_ff;
      fill_in     = fill_ff;
      rsp         = '0;

      if (req.kind == KIND_TIMEOUT) begin
         pos_in = '0;
         cls_in = CLS_UNDECIDED;
         if (frame_open) begin
            pclass_in = PC_DISCARD;
         end
         rsp.payload_discarded = 1'b1;
      end else begin
         if (pos_ff == POS_LEN) begin
            len_ok_in = (req.data_byte == 8'(HDR_LEN));
         end else if (pos_ff == POS_FLAGS) begin
            flags_in = req.data_byte;
         end else if (pos_ff inside {[POS_PTS0:POS_PTS3]}) begin
            pts_in[pts_idx] = req.data_byte;
         end
         if (pos_ff == POS_HDR_LAST) begin
            cls_in = cls_hdr;
         end

         if (wr_can && wr_offs < SUM_W'(frame_bytes)
             && 32'(wr_offs) < 32'(MAX_FRAME_BYTES)) begin
            rsp.write_enable = 1'b1;
            rsp.write_offset = wr_offs[OFFSET_W-1:0];
            rsp.write_byte   = req.data_byte;
         end

         if (payload_end) begin
            pos_in = '0;
            cls_in = CLS_UNDECIDED;
            if (cls_now == CLS_UNDECIDED || cls_now == CLS_BAD || pos_ff < POS_HDR_LAST) begin
               if (frame_open) begin
                  pclass_in = PC_DISCARD;
               end
               rsp.payload_discarded = 1'b1;
            end else if (cls_now == CLS_NEW) begin
               // A new frame begins; an unfinished one is dropped.
               rsp.payload_discarded = (pclass_ff == PC_INTER);
               prev_pts_in = pts_ff;
               prev_fid_in = flags_ff[FLAG_FID_BIT];
               fill_in     = '0;
               pclass_in   = PC_FIRST;
               if (data_n != '0) begin
                  if (FRAME_BYTES_W'(data_n) > frame_bytes) begin
                     pclass_in             = PC_DISCARD;
                     rsp.payload_discarded = 1'b1;
                  end else begin
                     fill_in = FRAME_BYTES_W'(data_n);
                  end
               end
            end else if (cls_now == CLS_EOF) begin
               prev_pts_in = '0;
               if (fill_sum != SUM_W'(frame_bytes)) begin
                  if (frame_open) begin
                     pclass_in = PC_DISCARD;
                  end
                  rsp.payload_discarded = 1'b1;
               end else if (pclass_ff == PC_DISCARD) begin
                  pclass_in             = PC_LAST;
                  fill_in               = '0;
                  rsp.payload_discarded = 1'b1;
               end else if (pclass_ff == PC_LAST) begin
                  rsp.payload_discarded = 1'b1;
               end else begin
                  pclass_in      = PC_LAST;
                  fill_in        = '0;
                  rsp.frame_done = 1'b1;
               end
            end else begin
               // Continuation payload.
               if (!frame_open) begin
                  rsp.payload_discarded = 1'b1;
               end else if (data_n != '0 && fill_sum > SUM_W'(frame_bytes)) begin
                  pclass_in             = PC_DISCARD;
                  fill_in               = '0;
                  rsp.payload_discarded = 1'b1;
               end else begin
                  fill_in   = fill_sum[FRAME_BYTES_W-1:0];
                  pclass_in = PC_INTER;
               end
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         flags_ff    <= '0;
         len_ok_ff   <= 1'b0;
         pts_ff      <= '0;
         prev_pts_ff <= '0;
         prev_fid_ff <= 1'b0;
         pclass_ff   <= PC_DISCARD;
         cls_ff      <= CLS_UNDECIDED;
         fill_ff     <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         flags_ff    <= flags_in;
         len_ok_ff   <= len_ok_in;
         pts_ff      <= pts_in;
         prev_pts_ff <= prev_pts_in;
         prev_fid_ff <= prev_fid_in;
         pclass_ff   <= pclass_in;
         cls_ff      <= cls_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

// ===== design/uvc_payload_frame_assembler_core.sv =====
// Top level of the bulk payload frame assembler.
//
// The req_ channel carries one word per received bulk byte (or a timeout
// event); the rsp_ channel returns exactly one result word for each request
// word, in order, telling the frame store whether and where to write the byte
// and whether a frame was completed or a payload discarded at this point.
// The csr_ port writes the expected frame size; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Each accepted request word's result is registered in the result register
// (the skid register while rsp_ is held). Throughput is one word per cycle
// while the skid register is empty, set by the single pass through the header
// parser and frame tracker, keeping all state in registers updated per word.
// A result register and a one-word skid register sit in front of rsp_. When
// the receiver stalls, the result is held and one more request word is taken
// into the skid register; req_stall then rises until the skid drains.
// req_stall is a register output and never depends on rsp_stall in the same
// cycle.
// Synchronous reset clears all tracking state, drops any pending results,
// and loads the frame size register with its default of 614400 bytes.
`include "uvc_payload_frame_assembler_core_defines.svh"

module uvc_payload_frame_assembler_core
   import upfa_pkg::*;
#(
   parameter int PAYLOAD_BYTES   = 2048,
   parameter int MAX_FRAME_BYTES = 1048576
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic [FRAME_BYTES_W-1:0] csr_wr_data
);

   logic [FRAME_BYTES_W-1:0] frame_bytes_ff, frame_bytes_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   rsp_type                  skid_data_ff, skid_data_in;

   logic                     accept;
   logic                     rsp_free;
   rsp_type                  step_rsp;

   // A word is taken whenever the skid register is empty.
   assign accept   = req_valid && !skid_valid_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   upfa_parser #(
      .PAYLOAD_BYTES   (PAYLOAD_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .frame_bytes (frame_bytes_ff),
      .rsp         (step_rsp)
   );

   assign frame_bytes_in = csr_wr_en ? csr_wr_data : frame_bytes_ff;

   // Output register and skid register. The skid word always moves to the
   // output before any newer result, so ordering is preserved.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = step_rsp;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bytes_ff <= FRAME_BYTES_RESET;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         frame_bytes_ff <= frame_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid register is only ever occupied behind a held result.
   `UPFA_ASSERT_NOW(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff, "skid word without output word")
   // A word accepted while the output is held must land in the skid register.
   `UPFA_ASSERT_NEXT(a_skid_load, clock, reset, accept && rsp_valid_ff && rsp_stall, skid_valid_ff, "accepted word lost under stall")
   // A completed frame is never reported as discarded in the same result.
   `UPFA_ASSERT_NOW(a_done_xor_disc, clock, reset, rsp_valid_ff, !(rsp_data_ff.frame_done && rsp_data_ff.payload_discarded), "frame done and discarded together")
   // Without a store write, the address and data fields are zero.
   `UPFA_ASSERT_NOW(a_idle_write_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.write_enable, rsp_data_ff.write_offset == '0 && rsp_data_ff.write_byte == '0, "write fields set without write enable")

endmodule

// ===== tb/uvc_payload_frame_assembler_core_tb.sv =====
// Self-checking testbench for the bulk payload frame assembler core.
module uvc_payload_frame_assembler_core_tb
   import upfa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAYLOAD_BYTES   = 2048;
   localparam int unsigned MAX_FRAME_BYTES = 1048576;
   localparam int unsigned WATCHDOG_LIMIT  = 1500;
   localparam int unsigned RANDOM_WORDS    = 300;
   localparam int unsigned PHASE_WORDS     = 60;
   localparam int unsigned LONG_HOLD       = 240;

   localparam logic [7:0] F_PTS = 8'(1 << FLAG_PTS_BIT);
   localparam logic [7:0] F_EOF = 8'(1 << FLAG_EOF_BIT);
   localparam logic [7:0] F_FID = 8'(1 << FLAG_FID_BIT);

   // The scoreboard carries its own copy of the header parser and frame
   // tracker. Every accepted request word is run through it, and the result
   // word that it predicts waits in a queue until the block returns one.
   class frame_scoreboard;
      bit [FRAME_BYTES_W-1:0] frame_bytes;
      bit [10:0]              payload_pos;
      bit [7:0]               hdr_flags;
      bit                     hdr_len_ok;
      bit [31:0]              pts_acc;
      bit [31:0]              frame_pts;
      bit                     frame_fid;
      pclass_type             frame_state;
      cls_type                payload_cls;
      bit [FRAME_BYTES_W-1:0] fill;
      rsp_type                expected_q[$];
      int unsigned            errors, reported, checked;
      int unsigned            frames_done, discards, writes;

      function new();
         frame_bytes = FRAME_BYTES_RESET;
         payload_pos = '0;
         hdr_flags   = '0;
         hdr_len_ok  = 1'b0;
         pts_acc     = '0;
         frame_pts   = '0;
         frame_fid   = 1'b0;
         frame_state = PC_DISCARD;
         payload_cls = CLS_UNDECIDED;
         fill        = '0;
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction

      // An open frame (first or intermediate payload seen) is abandoned; a
      // frame that has already completed stays complete.
      function void drop_frame();
         if (frame_state == PC_FIRST || frame_state == PC_INTER)
            frame_state = PC_DISCARD;
      endfunction

      function void note_word(req_type w);
         rsp_type     r;
         int unsigned p, o, n, len;
         bit          can, done, disc;
         r    = '0;
         can  = 1'b0;
         done = 1'b0;
         disc = 1'b0;
         o    = 0;
         p    = payload_pos;
         if (w.kind == KIND_TIMEOUT) begin
            // A timeout abandons the payload in flight without deciding it.
            payload_pos = '0;
            payload_cls = CLS_UNDECIDED;
            drop_frame();
            disc = 1'b1;
         end else begin
            if (p == HDR_LEN_POS)
               hdr_len_ok = (w.data_byte == HDR_LEN);
            else if (p == HDR_FLAGS_POS)
               hdr_flags = w.data_byte;
            else if (p >= HDR_PTS_POS && p < HDR_PTS_POS + HDR_PTS_BYTES)
               pts_acc[8*(p-HDR_PTS_POS) +: 8] = w.data_byte;

            // The last header byte classifies the payload.
            if (p == HDR_LEN - 1) begin
               if (!hdr_len_ok || hdr_flags[FLAG_ERR_BIT] || !hdr_flags[FLAG_PTS_BIT])
                  payload_cls = CLS_BAD;
               else if (pts_acc != frame_pts || hdr_flags[FLAG_FID_BIT] != frame_fid)
                  payload_cls = CLS_NEW;
               else if (hdr_flags[FLAG_EOF_BIT])
                  payload_cls = CLS_EOF;
               else
                  payload_cls = CLS_CONT;
            end

            // Data bytes are written speculatively while they fit the frame.
            if (p >= HDR_LEN) begin
               if (payload_cls == CLS_NEW) begin
                  can = 1'b1;
                  o   = p - HDR_LEN;
               end else if ((payload_cls == CLS_CONT || payload_cls == CLS_EOF) &&
                            (frame_state == PC_FIRST || frame_state == PC_INTER)) begin
                  can = 1'b1;
                  o   = fill + p - HDR_LEN;
               end
               if (can && o < frame_bytes && o < MAX_FRAME_BYTES) begin
                  r.write_enable = 1'b1;
                  r.write_offset = o[OFFSET_W-1:0];
                  r.write_byte   = w.data_byte;
               end
            end

            // The keep or drop decision falls on the last byte of a payload.
            if (w.transfer_end || p + 1 >= PAYLOAD_BYTES) begin
               len = p + 1;
               if (payload_cls == CLS_UNDECIDED || payload_cls == CLS_BAD || len < HDR_LEN) begin
                  drop_frame();
                  disc = 1'b1;
               end else begin
                  n = len - HDR_LEN;
                  case (payload_cls)
                     CLS_NEW: begin
                        if (frame_state == PC_INTER) begin
                           drop_frame();
                           disc = 1'b1;
                        end
                        frame_pts   = pts_acc;
                        frame_fid   = hdr_flags[FLAG_FID_BIT];
                        fill        = '0;
                        frame_state = PC_FIRST;
                        if (n > 0) begin
                           if (n > frame_bytes) begin
                              frame_state = PC_DISCARD;
                              disc        = 1'b1;
                           end else begin
                              fill = FRAME_BYTES_W'(n);
                           end
                        end
                     end
                     CLS_EOF: begin
                        frame_pts = '0;
                        if (fill + n != frame_bytes) begin
                           drop_frame();
                           disc = 1'b1;
                        end else if (frame_state == PC_DISCARD) begin
                           frame_state = PC_LAST;
                           fill        = '0;
                           disc        = 1'b1;
                        end else if (frame_state == PC_LAST) begin
                           disc = 1'b1;
                        end else begin
                           frame_state = PC_LAST;
                           fill        = '0;
                           done        = 1'b1;
                        end
                     end
                     default: begin
                        if (frame_state == PC_DISCARD || frame_state == PC_LAST) begin
                           disc = 1'b1;
                        end else if (n > 0 && fill + n > frame_bytes) begin
                           frame_state = PC_DISCARD;
                           fill        = '0;
                           disc        = 1'b1;
                        end else begin
                           fill        = FRAME_BYTES_W'(fill + n);
                           frame_state = PC_INTER;
                        end
                     end
                  endcase
               end
               payload_pos = '0;
               payload_cls = CLS_UNDECIDED;
            end else begin
               payload_pos = 11'(p + 1);
            end
         end
         r.frame_done        = done;
         r.payload_discarded = disc;
         writes      += r.write_enable;
         frames_done += done;
         discards    += disc;
         expected_q.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("[%0t] result word %0d arrived with nothing expected", $time, checked);
            end
            return;
         end
         want = expected_q.pop_front();
         if (got.write_enable      !== want.write_enable ||
             got.write_offset      !== want.write_offset ||
             got.write_byte        !== want.write_byte   ||
             got.frame_done        !== want.frame_done   ||
             got.payload_discarded !== want.payload_discarded) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("[%0t] result word %0d differs: expected we=%0b off=%0d byte=%02h",
                        $time, checked, want.write_enable, want.write_offset,
                        want.write_byte);
               $display("      done=%0b disc=%0b, got we=%0b off=%0d byte=%02h done=%0b disc=%0b",
                        want.frame_done, want.payload_discarded, got.write_enable,
                        got.write_offset, got.write_byte, got.frame_done,
                        got.payload_discarded);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_type                  req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wr_en   = 1'b0;
   logic [FRAME_BYTES_W-1:0] csr_wr_data = '0;

   frame_scoreboard sb = new();

   // Shared between the sender, the receiver and the sequence below.
   bit          quiet       = 1'b0;   // both sides stop idling while set
   bit          offering    = 1'b0;   // req_valid has been raised by the sender
   bit          stream_fid  = 1'b0;
   int unsigned hold_cycles = 0;      // one-off long stall request for the receiver
   int unsigned words_sent  = 0;
   int unsigned settings    = 0;

   uvc_payload_frame_assembler_core #(
      .PAYLOAD_BYTES   (PAYLOAD_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one request word after a random gap and returns once it has been
   // taken. Valid is only lowered when a gap follows, so back-to-back words
   // keep it high without a second assignment in the same step.
   task automatic send_word(input logic kind, input logic [7:0] value, input logic last);
      req_type     w;
      int unsigned gap;
      w.kind         = kind;
      w.data_byte    = value;
      w.transfer_end = last;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      offering = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      words_sent++;
   endtask

   task automatic send_timeout();
      send_word(KIND_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // One payload: the 12 header bytes (length, flags, PTS low byte first,
   // then filler) followed by data. A payload of fewer than 12 bytes is cut
   // short inside its header. When abort_at is reached, a timeout takes the
   // place of the rest of the payload.
   task automatic send_payload(input logic [7:0] len_byte, input logic [7:0] flags,
                               input logic [31:0] pts, input int total,
                               input bit mark_end, input int abort_at);
      logic [7:0] b;
      for (int i = 0; i < total; i++) begin
         if (i == abort_at) begin
            send_timeout();
            break;
         end
         if (i == HDR_LEN_POS)
            b = len_byte;
         else if (i == HDR_FLAGS_POS)
            b = flags;
         else if (i >= HDR_PTS_POS && i < HDR_PTS_POS + HDR_PTS_BYTES)
            b = pts[8*(i-HDR_PTS_POS) +: 8];
         else
            b = 8'($urandom_range(0, 255));
         send_word(KIND_BYTE, b, mark_end && i == total - 1);
      end
   endtask

   // A frame is a new-PTS payload, some continuation payloads and an EOF
   // payload, all under the same PTS and FID. A broken frame has each of its
   // payloads damaged now and then: bad header fields, a short payload, a
   // timeout in the middle, a lost payload, a stray timeout in front, a
   // flipped EOF bit or a missing transfer end.
   task automatic send_frame(input int unsigned data_total, input bit broken);
      int unsigned npay, remaining, piece;
      int          plen, abort_at, c;
      logic [31:0] pts;
      logic [7:0]  flags, len_byte;
      bit          mark_end;
      npay = $urandom_range(2, 4);
      pts  = $urandom();
      if (pts == 0)
         pts = 1;
      if ($urandom_range(0, 3) != 0)
         stream_fid = ~stream_fid;
      remaining = data_total;
      for (int j = 0; j < npay; j++) begin
         piece = (j == npay - 1) ? remaining : $urandom_range(0, remaining);
         remaining -= piece;
         flags = 8'($urandom_range(0, 255));
         flags[FLAG_ERR_BIT] = 1'b0;
         flags[FLAG_PTS_BIT] = 1'b1;
         flags[FLAG_FID_BIT] = stream_fid;
         flags[FLAG_EOF_BIT] = (j == npay - 1);
         len_byte = 8'(HDR_LEN);
         plen     = HDR_LEN + piece;
         mark_end = 1'b1;
         abort_at = -1;
         if (broken) begin
            c = $urandom_range(0, 99);
            if (c < 8) begin
               flags[FLAG_ERR_BIT] = 1'b1;
            end else if (c < 16) begin
               len_byte = 8'($urandom_range(0, 255));
               if (len_byte == HDR_LEN)
                  len_byte = 8'hFF;
            end else if (c < 24) begin
               flags[FLAG_PTS_BIT] = 1'b0;
            end else if (c < 32) begin
               plen = $urandom_range(1, HDR_LEN - 1);
            end else if (c < 40) begin
               abort_at = $urandom_range(0, plen - 1);
            end else if (c < 48) begin
               plen = 0;
            end else if (c < 56) begin
               send_timeout();
            end else if (c < 60) begin
               flags[FLAG_EOF_BIT] = ~flags[FLAG_EOF_BIT];
            end else if (c < 64) begin
               mark_end = 1'b0;
            end
         end
         send_payload(len_byte, flags, pts, plen, mark_end, abort_at);
      end
   endtask

   // Withdraws the request, then waits until every predicted result word has
   // come back and the result pipeline has settled.
   task automatic wait_idle();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_frame_bytes(input logic [FRAME_BYTES_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.frame_bytes = value;
      settings++;
   endtask

   // Receiver: stalls for a random number of cycles before each result word,
   // or for one long stretch when the sequence asks for it, then takes the
   // word and hands it to the scoreboard.
   initial begin
      int unsigned n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = quiet ? 0 : $urandom_range(0, 13);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   // Watchdog: ends the run when no word has moved on either channel for
   // too long.
   initial begin
      int unsigned idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("uvc_payload_frame_assembler_core verification failed");
      $finish;
   end

   initial begin
      int unsigned fb, total, phase_end, directed_words, c;
      logic [31:0] pts;
      bit          paused;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Under the reset frame size: a timeout with no frame
      // open and a two-byte payload whose header never completes. Then, with
      // a frame size of one byte, a new frame holding one data byte and an
      // empty EOF payload that completes it.
      send_timeout();
      send_payload(8'hFF, 8'h00, 32'h0, 2, 1'b1, -1);
      write_frame_bytes(FRAME_BYTES_W'(1));
      send_payload(8'(HDR_LEN), F_PTS | F_FID, 32'hFFFF_FFFF, HDR_LEN + 1, 1'b1, -1);
      send_payload(8'(HDR_LEN), F_PTS | F_FID | F_EOF, 32'hFFFF_FFFF, HDR_LEN, 1'b1, -1);
      stream_fid = 1'b1;
      directed_words = words_sent;

      // Random part, in phases with their own frame size. Most traffic is
      // well-formed frames with random content; the rest is damaged frames,
      // loose noise words and timeouts. One phase runs with a zero frame size
      // and one with a single byte; every third phase has no idling at all.
      for (int phase = 0; phase < 5 || words_sent < directed_words + RANDOM_WORDS; phase++) begin
         if (phase == 2)
            fb = 0;
         else if (phase == 4)
            fb = 1;
         else
            fb = $urandom_range(2, 80);
         write_frame_bytes(FRAME_BYTES_W'(fb));
         quiet = (phase % 3 == 1);
         // In the second phase the receiver holds off for a long stretch
         // while words keep being offered, so the block fills and stalls.
         if (phase == 1)
            hold_cycles = LONG_HOLD;
         phase_end = words_sent + PHASE_WORDS;
         paused = 1'b0;
         while (words_sent < phase_end) begin
            c = $urandom_range(0, 99);
            total = fb;
            if ($urandom_range(0, 99) < 15) begin
               total = fb + $urandom_range(0, 4);
               total = (total >= 2) ? total - 2 : 0;
            end
            if (c < 70) begin
               send_frame(total, 1'b0);
            end else if (c < 85) begin
               send_frame(total, 1'b1);
            end else if (c < 93) begin
               repeat ($urandom_range(1, 16))
                  send_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                            $urandom_range(0, 3) == 0);
            end else begin
               send_timeout();
            end
            // Once, mid-phase, the sender stops until the block has drained.
            if (phase == 3 && !paused && words_sent + PHASE_WORDS / 2 > phase_end) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end

      // The largest frame size, with one payload that runs to the full
      // payload length and is cut by the block, then an EOF that misses.
      quiet = 1'b0;
      write_frame_bytes(FRAME_BYTES_W'(MAX_FRAME_BYTES));
      pts = $urandom() | 32'h1;
      stream_fid = ~stream_fid;
      send_payload(8'(HDR_LEN), F_PTS | (stream_fid ? F_FID : 8'h00), pts, PAYLOAD_BYTES,
                   1'b0, -1);
      send_payload(8'(HDR_LEN), F_PTS | F_EOF | (stream_fid ? F_FID : 8'h00), pts,
                   HDR_LEN + 20, 1'b1, -1);

      wait_idle();

      $display("Sent %0d words over %0d frame size settings; %0d result words checked.",
               words_sent, settings, sb.checked);
      $display("Frames completed: %0d, discards: %0d, frame store writes: %0d.",
               sb.frames_done, sb.discards, sb.writes);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("uvc_payload_frame_assembler_core verification clean");
      end else begin
         $display("%0d result errors, %0d results never arrived",
                  sb.errors, sb.outstanding());
         $display("uvc_payload_frame_assembler_core verification failed");
      end
      $finish;
   end

endmodule
